// ----- rtl/core/curve_gaussian_derivative_filter_macros.svh -----
// ----------------------------------------------------------------------------
// Curve Gaussian derivative filter assertion macros
// Shared concurrent assertion forms, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CURVE_GAUSSIAN_DERIVATIVE_FILTER_MACROS_SVH
`define CURVE_GAUSSIAN_DERIVATIVE_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define CGDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cgdf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CGDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cgdf assertion failed");

`else

`define CGDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CGDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/cgdf_pkg.sv -----
// ----------------------------------------------------------------------------
// Curve Gaussian derivative filter package
// Sizes, request and result types, and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cgdf_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int MAX_HALF   = 15;
	localparam int TAPS       = 2 * MAX_HALF + 1;

	localparam int PT_W   = $clog2(MAX_POINTS);
	localparam int LEN_W  = PT_W + 1;
	localparam int HALF_W = $clog2(MAX_HALF + 1);
	localparam int TAP_W  = $clog2(TAPS);
	localparam int COEF_W = 24;
	localparam int SMP_W  = 24;
	localparam int RES_W  = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = HALF_W;

	typedef enum logic [1:0] {
		OP_LOAD_COEF    = 2'd0,
		OP_WRITE_SAMPLE = 2'd1,
		OP_COMPUTE      = 2'd2
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_ENDS  = 1'd1;

	typedef struct packed {
		logic [1:0]               op;
		logic [PT_W-1:0]          point_index;
		logic [TAP_W-1:0]         coef_index;
		logic signed [COEF_W-1:0] coef_gauss;
		logic signed [COEF_W-1:0] coef_first;
		logic signed [COEF_W-1:0] coef_second;
		logic signed [SMP_W-1:0]  sample;
		logic [LEN_W-1:0]         curve_length;
	} req_t;

	typedef struct packed {
		logic [PT_W-1:0]         out_index;
		logic signed [RES_W-1:0] smoothed;
		logic signed [RES_W-1:0] first_deriv;
		logic signed [RES_W-1:0] second_deriv;
		logic                    error;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic wr_coef;
		logic wr_sample;
		logic start;
		logic issue;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic req_error;
		logic last_tap;
		logic pipe_empty;
	} sts_t;

endpackage

// ----- rtl/core/cgdf_ctrl.sv -----
// ----------------------------------------------------------------------------
// Curve Gaussian derivative filter controller
// Accepts requests, sequences the taps of a compute and hands off the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cgdf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    op,
	output logic          out_valid,
	input  logic          out_ready,
	output cgdf_pkg::cmd_t cmd,
	input  cgdf_pkg::sts_t sts
);
	import cgdf_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (op)
						OP_LOAD_COEF: begin
							cmd.wr_coef = 1'b1;
						end
						OP_WRITE_SAMPLE: begin
							cmd.wr_sample = 1'b1;
						end
						OP_COMPUTE: begin
							cmd.start = 1'b1;
							state_d   = sts.req_error ? ST_FINISH : ST_ISSUE;
						end
						default: begin
						end
					endcase
				end
			end
			ST_ISSUE: begin
				cmd.issue = 1'b1;
				if (sts.last_tap) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// Wait for the last product to land and for the output slot to free up.
				if (sts.pipe_empty && out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/core/cgdf_datapath.sv -----
// ----------------------------------------------------------------------------
// Curve Gaussian derivative filter datapath
// Sample and kernel memories, border addressing, three MAC lanes and rounding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cgdf_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cgdf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cgdf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  cgdf_pkg::req_t                 request,
	input  cgdf_pkg::cmd_t                 cmd,
	output cgdf_pkg::sts_t                 sts,
	output cgdf_pkg::rsp_t                 result
);
	import cgdf_pkg::*;

	localparam int PROD_W     = COEF_W + SMP_W;
	localparam int ACC_W      = PROD_W + 8;
	localparam int FRAC_SHIFT = 22;
	localparam int SH_W       = ACC_W - FRAC_SHIFT;
	localparam int NK_W       = LEN_W + 2;
	localparam int CROW_W     = 3 * COEF_W;

	localparam logic [ACC_W-1:0] RND_POS = ACC_W'(1) << (FRAC_SHIFT - 1);
	localparam logic [ACC_W-1:0] RND_NEG = RND_POS - ACC_W'(1);

	// Round half away from zero with an arithmetic shift, then saturate.
	function automatic logic signed [RES_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] biased;
		logic signed [SH_W-1:0]  sh;
		logic signed [RES_W-1:0] r;
		biased = acc + (acc[ACC_W-1] ? RND_NEG : RND_POS);
		sh     = biased[ACC_W-1:FRAC_SHIFT];
		if (sh[SH_W-1:RES_W-1] != {(SH_W-RES_W+1){sh[SH_W-1]}}) begin
			r = sh[SH_W-1] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
		end else begin
			r = sh[RES_W-1:0];
		end
		return r;
	endfunction

	// Configuration registers
	logic [HALF_W-1:0] half_width_q;
	logic              open_ends_q;
	logic [HALF_W-1:0] eff_half;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= HALF_W'(1);
			open_ends_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HALF_WIDTH: half_width_q <= cfg_data[HALF_W-1:0];
				CFG_OPEN_ENDS:  open_ends_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// A half width of zero behaves as one.
	assign eff_half = (half_width_q == '0) ? HALF_W'(1) : half_width_q;

	assign sts.req_error = (request.curve_length < (LEN_W'(eff_half) + LEN_W'(1)))
		|| (request.curve_length > LEN_W'(MAX_POINTS))
		|| (LEN_W'(request.point_index) >= request.curve_length);

	// Request context latched at the start of a compute
	logic [PT_W-1:0]   n_q;
	logic [LEN_W-1:0]  len_q;
	logic [HALF_W-1:0] half_q;
	logic              open_q;
	logic              err_q;
	logic [TAP_W-1:0]  tap_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			n_q    <= request.point_index;
			len_q  <= request.curve_length;
			half_q <= eff_half;
			open_q <= open_ends_q;
			err_q  <= sts.req_error;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (cmd.start) begin
			tap_q <= '0;
		end else if (cmd.issue) begin
			tap_q <= tap_q + TAP_W'(1);
		end
	end

	assign sts.last_tap = (tap_q == TAP_W'({half_q, 1'b0}));

	// Sample position n - k for tap k = tap - L, folded back onto the curve.
	logic signed [NK_W-1:0] nk;
	logic signed [NK_W-1:0] lenx;
	logic signed [NK_W-1:0] idx_raw;
	logic [PT_W-1:0]        smp_addr;

	always_comb begin
		nk   = NK_W'(n_q) + NK_W'(half_q) - NK_W'(tap_q);
		lenx = NK_W'(len_q);
		if (nk < 0) begin
			idx_raw = open_q ? -nk : lenx + nk;
		end else if (nk > lenx - NK_W'(1)) begin
			// Open curves reflect about the last sample.
			idx_raw = open_q ? (lenx <<< 1) - NK_W'(2) - nk : nk - lenx;
		end else begin
			idx_raw = nk;
		end
		if (idx_raw < 0 || idx_raw >= lenx) begin
			smp_addr = '0;
		end else begin
			smp_addr = idx_raw[PT_W-1:0];
		end
	end

	// Memories
	logic [SMP_W-1:0]  smp_mem [MAX_POINTS];
	logic [CROW_W-1:0] coef_mem [TAPS];

	always_ff @(posedge clk) begin
		if (cmd.wr_sample && (LEN_W'(request.point_index) < LEN_W'(MAX_POINTS))) begin
			smp_mem[request.point_index] <= request.sample;
		end
		if (cmd.wr_coef && (request.coef_index < TAP_W'(TAPS))) begin
			coef_mem[request.coef_index] <=
				{request.coef_gauss, request.coef_first, request.coef_second};
		end
	end

	logic signed [SMP_W-1:0]  smp_s1;
	logic [CROW_W-1:0]        crow_s1;
	logic signed [PROD_W-1:0] pg_s2, p1_s2, p2_s2;
	logic                     v_s1, v_s2;

	always_ff @(posedge clk) begin
		smp_s1  <= smp_mem[smp_addr];
		crow_s1 <= coef_mem[tap_q];
		pg_s2   <= $signed(crow_s1[3*COEF_W-1:2*COEF_W]) * smp_s1;
		p1_s2   <= $signed(crow_s1[2*COEF_W-1:COEF_W]) * smp_s1;
		p2_s2   <= $signed(crow_s1[COEF_W-1:0]) * smp_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	assign sts.pipe_empty = !v_s1 && !v_s2;

	logic signed [ACC_W-1:0] acc_g_q, acc_1_q, acc_2_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_g_q <= '0;
			acc_1_q <= '0;
			acc_2_q <= '0;
		end else if (v_s2) begin
			acc_g_q <= acc_g_q + ACC_W'(pg_s2);
			acc_1_q <= acc_1_q + ACC_W'(p1_s2);
			acc_2_q <= acc_2_q + ACC_W'(p2_s2);
		end
	end

	// Output register
	rsp_t out_q;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.out_index    <= n_q;
			out_q.error        <= err_q;
			out_q.smoothed     <= err_q ? '0 : round_sat(acc_g_q);
			out_q.first_deriv  <= err_q ? '0 : round_sat(acc_1_q);
			out_q.second_deriv <= err_q ? '0 : round_sat(acc_2_q);
		end
	end

	assign result = out_q;

endmodule

// ----- rtl/core/curve_gaussian_derivative_filter.sv -----
// ----------------------------------------------------------------------------
// Curve Gaussian derivative filter: smoothing plus first and second derivative.
// Coefficient loads and sample writes are taken one request per cycle while no compute runs.
// A compute runs one tap per cycle through the sample memory; no new request is
// taken until the pipeline has drained and the result is loaded for output.
// Reset clears control and sets half width to 1 and closed curves; memories are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "curve_gaussian_derivative_filter_macros.svh"

module curve_gaussian_derivative_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cgdf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cgdf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  cgdf_pkg::req_t                  request,
	output logic                            out_valid,
	input  logic                            out_ready,
	output cgdf_pkg::rsp_t                  result
);
	import cgdf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	cgdf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (request.op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	cgdf_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.request   (request),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result)
	);

	// No new request is taken while taps are being issued.
	`CGDF_ASSERT_IMP(a_no_accept_in_issue, clk, arst_n, cmd.issue, !in_ready)

	// A pending result is never overwritten.
	`CGDF_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.load_out, !out_valid || out_ready)

	// A valid compute request starts the tap sequence right away.
	`CGDF_ASSERT_NXT(a_compute_issues, clk, arst_n,
		in_valid && in_ready && (request.op == OP_COMPUTE) && !sts.req_error,
		cmd.issue && !in_ready)

endmodule

// ----- bench/curve_gaussian_derivative_filter_test.sv -----
// ----------------------------------------------------------------------------
// Curve Gaussian derivative filter testbench
// Loads kernel taps and curve samples, then filters points on closed and open
// curves at several half widths. A local predictor computes each expected
// result, and a checker compares every result field with the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module curve_gaussian_derivative_filter_test;

	import cgdf_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int PHASE_ITEMS    = 56;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	req_t request;
	logic out_valid;
	logic out_ready;
	rsp_t result;

	// Predictor copy of the block's state.
	logic signed [SMP_W-1:0] sample_mem [MAX_POINTS];
	logic signed [COEF_W-1:0] gauss_taps [TAPS];
	logic signed [COEF_W-1:0] slope_taps [TAPS];
	logic signed [COEF_W-1:0] bend_taps [TAPS];
	bit sample_set [MAX_POINTS];
	bit tap_set [TAPS];
	int unsigned half_reg;
	bit open_reg;

	rsp_t pending_filter_results [$];
	int items_sent;
	int results_checked;
	int failures;
	int phases_run;
	int stall_count;
	bit steady_flow;

	curve_gaussian_derivative_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.request(request),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int effective_half();
		if (half_reg < 1)
			return 1;
		if (half_reg > MAX_HALF)
			return MAX_HALF;
		return int'(half_reg);
	endfunction

	// Position read for tap k around point n: wrap on closed curves, reflect
	// about the first and the last sample on open ones.
	function automatic int fold_position(input int n, input int k, input int len);
		int nk;
		int idx;
		nk = n - k;
		if (nk < 0)
			idx = open_reg ? -nk : len + nk;
		else if (nk > len - 1)
			idx = open_reg ? 2 * (len - 1) - nk : nk - len;
		else
			idx = nk;
		if (idx < 0 || idx >= len)
			idx = 0;
		return idx;
	endfunction

	// Shift out 22 fraction bits, round half away from zero, saturate to 32 bits.
	function automatic logic signed [RES_W-1:0] round_to_q23_8(input longint acc);
		longint mag;
		longint rounded;
		logic signed [63:0] wide;
		mag = (acc < 0) ? -acc : acc;
		rounded = (mag + 64'sd2097152) >>> 22;
		if (acc < 0) begin
			if (rounded > 64'sd2147483648)
				rounded = 64'sd2147483648;
			wide = -rounded;
		end else begin
			if (rounded > 64'sd2147483647)
				rounded = 64'sd2147483647;
			wide = rounded;
		end
		return wide[RES_W-1:0];
	endfunction

	function automatic rsp_t filter_point(input req_t r);
		rsp_t res;
		int hw;
		int n;
		int len;
		int k;
		int idx;
		longint s;
		longint acc_g;
		longint acc_f;
		longint acc_s;
		hw = effective_half();
		n = int'(r.point_index);
		len = int'(r.curve_length);
		res = '0;
		res.out_index = r.point_index;
		if (len < hw + 1 || len > MAX_POINTS || n >= len) begin
			res.error = 1'b1;
			return res;
		end
		acc_g = 0;
		acc_f = 0;
		acc_s = 0;
		for (k = -hw; k <= hw; k++) begin
			idx = fold_position(n, k, len);
			s = sample_mem[idx];
			acc_g += s * longint'(gauss_taps[k + hw]);
			acc_f += s * longint'(slope_taps[k + hw]);
			acc_s += s * longint'(bend_taps[k + hw]);
		end
		res.smoothed = round_to_q23_8(acc_g);
		res.first_deriv = round_to_q23_8(acc_f);
		res.second_deriv = round_to_q23_8(acc_s);
		return res;
	endfunction

	function automatic void record_request(input req_t r);
		case (r.op)
			OP_LOAD_COEF: begin
				if (r.coef_index < TAPS) begin
					gauss_taps[r.coef_index] = r.coef_gauss;
					slope_taps[r.coef_index] = r.coef_first;
					bend_taps[r.coef_index] = r.coef_second;
					tap_set[r.coef_index] = 1'b1;
				end
			end
			OP_WRITE_SAMPLE: begin
				sample_mem[r.point_index] = r.sample;
				sample_set[r.point_index] = 1'b1;
			end
			OP_COMPUTE: pending_filter_results = {pending_filter_results, filter_point(r)};
			default: ;
		endcase
	endfunction

	function automatic int idle_cycles();
		int pick;
		pick = $urandom_range(0, 99);
		if (steady_flow || pick < 55)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 2);
		if (pick < 97)
			return $urandom_range(3, 6);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [23:0] random_word();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 24'sh7FFFFF;
		if (pick == 1)
			return 24'sh800000;
		return 24'($urandom);
	endfunction

	function automatic req_t random_request(input logic [1:0] op);
		req_t r;
		r.op = op;
		r.point_index = PT_W'($urandom);
		r.coef_index = TAP_W'($urandom);
		r.coef_gauss = COEF_W'($urandom);
		r.coef_first = COEF_W'($urandom);
		r.coef_second = COEF_W'($urandom);
		r.sample = SMP_W'($urandom);
		r.curve_length = LEN_W'($urandom);
		return r;
	endfunction

	task automatic send_request(input req_t r);
		int gap;
		gap = idle_cycles();
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		request = r;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
		record_request(r);
	endtask

	task automatic load_taps(input int tap, input logic signed [23:0] g,
			input logic signed [23:0] f, input logic signed [23:0] s);
		req_t r;
		r = random_request(OP_LOAD_COEF);
		r.coef_index = TAP_W'(tap);
		r.coef_gauss = g;
		r.coef_first = f;
		r.coef_second = s;
		send_request(r);
	endtask

	task automatic write_sample(input int pos, input logic signed [23:0] value);
		req_t r;
		r = random_request(OP_WRITE_SAMPLE);
		r.point_index = PT_W'(pos);
		r.sample = value;
		send_request(r);
	endtask

	// Writes whatever samples and taps the point would read before requesting it,
	// so that no entry is ever read before it was written.
	task automatic filter_request(input int pos, input int len);
		req_t r;
		int hw;
		int k;
		int idx;
		hw = effective_half();
		if (len >= hw + 1 && len <= MAX_POINTS && pos < len) begin
			for (k = -hw; k <= hw; k++) begin
				idx = fold_position(pos, k, len);
				if (!sample_set[idx])
					write_sample(idx, random_word());
			end
			for (k = 0; k <= 2 * hw; k++)
				if (!tap_set[k])
					load_taps(k, random_word(), random_word(), random_word());
		end
		r = random_request(OP_COMPUTE);
		r.point_index = PT_W'(pos);
		r.curve_length = LEN_W'(len);
		send_request(r);
	endtask

	// Lets the block drain before a register changes.
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_filter_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		settle();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_HALF_WIDTH)
			half_reg = 32'(data);
		else
			open_reg = data[0];
	endtask

	task automatic test_table_and_sample_loads();
		load_taps(0, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
		load_taps(1, 24'sh800000, 24'sh7FFFFF, 24'sh800000);
		load_taps(2, 24'sh000001, 24'shFFFFFF, 24'sh400000);
		// A tap index past the table must leave the tables alone.
		load_taps(31, random_word(), random_word(), random_word());
		write_sample(0, 24'sh7FFFFF);
		write_sample(1, 24'sh800000);
		write_sample(2, 24'sh000000);
		write_sample(3, 24'shFFFFFF);
		write_sample(1022, 24'sh003039);
		write_sample(1023, 24'sh800000);
		send_request(random_request(OP_UNUSED));
	endtask

	task automatic test_closed_curve();
		filter_request(0, 4);
		filter_request(3, 4);
		filter_request(1, 4);
		filter_request(1, 2);
		filter_request(1023, 1024);
	endtask

	task automatic test_error_requests();
		filter_request(0, 1);
		filter_request(0, 0);
		filter_request(5, 1025);
		filter_request(0, 2047);
		filter_request(4, 4);
		filter_request(1023, 1023);
	endtask

	task automatic test_open_curve();
		write_reg(CFG_OPEN_ENDS, 4'd1);
		filter_request(0, 4);
		filter_request(3, 4);
	endtask

	task automatic test_half_width_zero();
		write_reg(CFG_HALF_WIDTH, 4'd0);
		filter_request(2, 4);
	endtask

	task automatic random_item();
		int pick;
		int hw;
		int len;
		int pos;
		req_t r;
		hw = effective_half();
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			load_taps($urandom_range(0, 31), random_word(), random_word(), random_word());
		end else if (pick < 30) begin
			pos = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 127) : $urandom_range(0, 1023);
			write_sample(pos, random_word());
		end else if (pick < 33) begin
			send_request(random_request(OP_UNUSED));
		end else if (pick < 40) begin
			pick = $urandom_range(0, 5);
			if (pick < 2) begin
				len = $urandom_range(0, hw);
				pos = $urandom_range(0, 1023);
			end else if (pick == 2) begin
				len = $urandom_range(1025, 2047);
				pos = $urandom_range(0, 1023);
			end else begin
				len = $urandom_range(hw + 1, 1023);
				pos = $urandom_range(len, 1023);
			end
			r = random_request(OP_COMPUTE);
			r.point_index = PT_W'(pos);
			r.curve_length = LEN_W'(len);
			send_request(r);
		end else begin
			pick = $urandom_range(0, 9);
			if (pick < 7)
				len = $urandom_range(hw + 1, hw + 48);
			else if (pick < 9)
				len = MAX_POINTS;
			else
				len = $urandom_range(hw + 1, MAX_POINTS);
			// Long curves mostly get points near the ends, where folding happens.
			if (len == MAX_POINTS && $urandom_range(0, 1))
				pos = $urandom_range(0, 1) ? $urandom_range(0, hw) :
					$urandom_range(MAX_POINTS - 1 - hw, MAX_POINTS - 1);
			else
				pos = $urandom_range(0, len - 1);
			filter_request(pos, len);
		end
	endtask

	task automatic test_random_traffic();
		int half_list [8];
		bit open_list [8];
		int i;
		int stop;
		half_list = '{15, 15, 1, 0, 7, 3, 15, 10};
		open_list = '{1, 0, 1, 0, 1, 0, 0, 1};
		for (i = 0; i < 8; i++) begin
			write_reg(CFG_HALF_WIDTH, CFG_DATA_W'(half_list[i]));
			// The upper data bits are noise for the one-bit register.
			write_reg(CFG_OPEN_ENDS, {3'($urandom_range(0, 7)), open_list[i]});
			steady_flow = (i == 2);
			stop = items_sent + PHASE_ITEMS;
			while (items_sent < stop)
				random_item();
			phases_run++;
		end
		steady_flow = 1'b0;
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_filter_results.size() == 0) begin
				$error("result for point %0d with no request outstanding", result.out_index);
				failures++;
			end else begin
				want = pending_filter_results.pop_front();
				check_field("out_index", want.out_index, result.out_index);
				check_field("smoothed", want.smoothed, result.smoothed);
				check_field("first_deriv", want.first_deriv, result.first_deriv);
				check_field("second_deriv", want.second_deriv, result.second_deriv);
				check_field("error", want.error, result.error);
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			stall_count = 0;
		end else begin
			stall_count++;
			if (stall_count >= WATCHDOG_LIMIT) begin
				$display("curve_gaussian_derivative_filter_test NOT OK");
				$finish;
			end
		end
	end

	initial begin
		int stall;
		out_ready = 1'b0;
		stall = 0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				out_ready = 1'b0;
				stall--;
			end else begin
				stall = idle_cycles();
				out_ready = (stall == 0);
				if (stall > 0)
					stall--;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		request = '0;
		half_reg = 1;
		open_reg = 1'b0;
		items_sent = 0;
		results_checked = 0;
		failures = 0;
		phases_run = 0;
		stall_count = 0;
		steady_flow = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_table_and_sample_loads();
		test_closed_curve();
		test_error_requests();
		test_open_curve();
		test_half_width_zero();
		test_random_traffic();

		settle();
		$display("Sent %0d requests and checked %0d filtered points", items_sent,
			results_checked);
		$display("over %0d random phases of half width and closed or open curve ends.",
			phases_run);
		if (failures == 0)
			$display("curve_gaussian_derivative_filter_test OK");
		else
			$display("curve_gaussian_derivative_filter_test NOT OK");
		$finish;
	end

endmodule

// ----- curve_gaussian_derivative_filter.f -----
+incdir+rtl/core
rtl/core/cgdf_pkg.sv
rtl/core/cgdf_ctrl.sv
rtl/core/cgdf_datapath.sv
rtl/core/curve_gaussian_derivative_filter.sv
bench/curve_gaussian_derivative_filter_test.sv
